### rtl/core/sv39ptw_pkg.sv
package sv39ptw_pkg;

    // Field widths
    localparam int unsigned PPN_W      = 44;
    localparam int unsigned VA_W       = 41;
    localparam int unsigned PA_W       = 56;
    localparam int unsigned PTE_W      = 64;
    localparam int unsigned OFFSET_W   = 12;
    localparam int unsigned IDX_W      = 9;
    localparam int unsigned ROOT_IDX_W = 11;
    localparam int unsigned LEVEL_W    = 2;
    localparam int unsigned PTE_SIZE_W = 3;

    // PTE layout
    localparam int unsigned PTE_V_BIT   = 0;
    localparam int unsigned PTE_PPN_LSB = 10;

    // Request commands
    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_RESPONSE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_ROOT_PPN   = 1'b0;
    localparam logic CFG_GUEST_MODE = 1'b1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } t_kind;

endpackage

### rtl/core/sv39ptw_addr.sv
module sv39ptw_addr #(
    parameter int unsigned LEVELS = 3
) (
    input  logic [sv39ptw_pkg::PPN_W-1:0]   i_table_ppn,
    input  logic [sv39ptw_pkg::VA_W-1:0]    i_vaddr,
    input  logic [sv39ptw_pkg::LEVEL_W-1:0] i_level,
    input  logic                            i_wide_root,
    output logic [sv39ptw_pkg::PA_W-1:0]    o_address
);
    import sv39ptw_pkg::*;

    logic [5:0]            shift_amt;
    logic [VA_W-1:0]       shifted;
    logic                  use_wide;
    logic [ROOT_IDX_W-1:0] index;

    // Select the VPN field of the current level
    assign shift_amt = 6'(i_level) * 6'(IDX_W) + 6'(OFFSET_W);
    assign shifted   = i_vaddr >> shift_amt;
    assign use_wide  = i_wide_root && (i_level == LEVEL_W'(LEVELS - 1));
    assign index     = use_wide ? shifted[ROOT_IDX_W-1:0]
                                : {{(ROOT_IDX_W-IDX_W){1'b0}}, shifted[IDX_W-1:0]};

    // Add the scaled index to the table base
    assign o_address = {i_table_ppn, {OFFSET_W{1'b0}}}
                     + {{(PA_W-ROOT_IDX_W-PTE_SIZE_W){1'b0}}, index, {PTE_SIZE_W{1'b0}}};

endmodule

### rtl/core/sv39_page_table_walker_core.sv
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// input     | i_in_valid/o_in_ready, i_cmd, i_vaddr,          | in
//           | i_read_data                                    |
// output    | o_out_valid/i_out_ready, o_kind, o_address     | out
// config    | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// A request passes capture, evaluate, and an address step on the shared entry
// address adder before its result; a done or fault result skips the address step.
// A request with no result frees the input after the evaluate step.
// The block takes no new request until its result has been taken.
// Reset (synchronous, active low) clears both registers, idles the walk
// and drops output valid. Config writes are taken every cycle.
module sv39_page_table_walker_core #(
    parameter int unsigned LEVELS = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_cmd,
    input  logic [sv39ptw_pkg::VA_W-1:0]     i_vaddr,
    input  logic [sv39ptw_pkg::PTE_W-1:0]    i_read_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_kind,
    output logic [sv39ptw_pkg::PA_W-1:0]     o_address,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [sv39ptw_pkg::PPN_W-1:0]    i_cfg_data
);
    import sv39ptw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ADDR,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [PPN_W-1:0]    r_root_ppn;
    logic                r_guest_mode;
    logic                r_walking;
    logic [LEVEL_W-1:0]  r_level;
    logic [VA_W-1:0]     r_saved_vaddr;
    logic [PPN_W-1:0]    r_table_ppn;
    logic                r_wide_root;
    logic                r_in_cmd;
    logic [VA_W-1:0]     r_in_vaddr;
    logic [PTE_W-1:0]    r_in_pte;
    t_kind               r_kind;
    logic [PA_W-1:0]     r_address;

    logic [PA_W-1:0]     entry_addr;
    logic [PPN_W-1:0]    pte_ppn;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_kind      = r_kind;
    assign o_address   = r_address;
    assign o_cfg_ready = 1'b1;
    assign pte_ppn     = r_in_pte[PTE_PPN_LSB +: PPN_W];

    // Shared entry address unit
    sv39ptw_addr #(
        .LEVELS(LEVELS)
    ) u_addr (
        .i_table_ppn(r_table_ppn),
        .i_vaddr    (r_saved_vaddr),
        .i_level    (r_level),
        .i_wide_root(r_wide_root),
        .o_address  (entry_addr)
    );

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_ppn   <= '0;
            r_guest_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROOT_PPN:   r_root_ppn   <= i_cfg_data;
                CFG_GUEST_MODE: r_guest_mode <= i_cfg_data[0];
                default:        r_guest_mode <= r_guest_mode;
            endcase
        end
    end

    // Sequence the walk and hold the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_walking     <= 1'b0;
            r_level       <= '0;
            r_saved_vaddr <= '0;
            r_table_ppn   <= '0;
            r_wide_root   <= 1'b0;
            r_kind        <= KIND_READ;
            r_address     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in_cmd   <= i_cmd;
                        r_in_vaddr <= i_vaddr;
                        r_in_pte   <= i_read_data;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_in_cmd == CMD_TRANSLATE) begin
                        // Start a walk, fault on a zero root, or drop a request while one runs
                        if (r_walking) begin
                            r_state <= S_IDLE;
                        end else if (r_root_ppn == '0) begin
                            r_kind    <= KIND_FAULT;
                            r_address <= PA_W'(r_in_vaddr);
                            r_state   <= S_OUT;
                        end else begin
                            r_saved_vaddr <= r_in_vaddr;
                            r_table_ppn   <= r_root_ppn;
                            r_wide_root   <= r_guest_mode;
                            r_level       <= LEVEL_W'(LEVELS - 1);
                            r_walking     <= 1'b1;
                            r_state       <= S_ADDR;
                        end
                    end else begin
                        // Consume a response: leaf, fault or next table; drop it when no walk runs
                        if (!r_walking) begin
                            r_state <= S_IDLE;
                        end else if (r_level == '0) begin
                            r_walking <= 1'b0;
                            r_kind    <= KIND_DONE;
                            r_address <= {pte_ppn, r_saved_vaddr[OFFSET_W-1:0]};
                            r_state   <= S_OUT;
                        end else if (!r_in_pte[PTE_V_BIT]) begin
                            r_walking <= 1'b0;
                            r_kind    <= KIND_FAULT;
                            r_address <= PA_W'(r_saved_vaddr);
                            r_state   <= S_OUT;
                        end else begin
                            r_table_ppn <= pte_ppn;
                            r_level     <= r_level - LEVEL_W'(1);
                            r_state     <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    r_kind    <= KIND_READ;
                    r_address <= entry_addr;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### sim/tb_sv39_page_table_walker_core.sv
`timescale 1ns / 1ps

module tb_sv39_page_table_walker_core;
    import sv39ptw_pkg::*;

    localparam int unsigned WALK_LEVELS    = 3;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS    = 320;

    typedef struct packed {
        t_kind           kind;
        logic [PA_W-1:0] address;
    } t_walk_result;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_ready;
    logic               i_cmd       = CMD_TRANSLATE;
    logic [VA_W-1:0]    i_vaddr     = '0;
    logic [PTE_W-1:0]   i_read_data = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [1:0]         o_kind;
    logic [PA_W-1:0]    o_address;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic               i_cfg_index = CFG_ROOT_PPN;
    logic [PPN_W-1:0]   i_cfg_data  = '0;

    // Walker shadow state and register copies
    logic               walk_active;
    logic [1:0]         walk_level;
    logic [VA_W-1:0]    walk_vaddr;
    logic [PPN_W-1:0]   walk_table_ppn;
    logic               walk_wide_root;
    logic [PPN_W-1:0]   cfg_root_ppn;
    logic               cfg_guest;

    t_walk_result       pending_results[$];
    t_walk_result       oldest_result;
    int unsigned        mismatch_count = 0;
    int unsigned        counted_items = 0;
    int unsigned        stall_cycles = 0;
    int unsigned        ready_hold = 0;
    int unsigned        ready_pick;
    bit                 ready_calm = 1'b1;
    bit                 burst_mode = 1'b0;

    sv39_page_table_walker_core #(
        .LEVELS(WALK_LEVELS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_vaddr     (i_vaddr),
        .i_read_data (i_read_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_kind      (o_kind),
        .o_address   (o_address),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Print one mismatch line and count it
    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Entry address for the current level of the shadow walk
    function automatic logic [PA_W-1:0] entry_addr();
        int unsigned sh;
        logic [10:0] mask;
        logic [10:0] idx;
        sh = walk_level * IDX_W + OFFSET_W;
        mask = (walk_level == 2'(WALK_LEVELS - 1) && walk_wide_root) ? 11'h7FF : 11'h1FF;
        idx = 11'(walk_vaddr >> sh) & mask;
        return {walk_table_ppn, 12'h000} + {42'b0, idx, 3'b000};
    endfunction

    // Advance the shadow walk by one accepted request; return 1 if a result follows
    function automatic bit predict_step(input logic cmd, input logic [VA_W-1:0] va,
                                        input logic [PTE_W-1:0] pte);
        t_walk_result res;
        logic [PPN_W-1:0] ppn;
        ppn = pte[PTE_PPN_LSB +: PPN_W];
        if (cmd == CMD_TRANSLATE) begin
            if (walk_active)
                return 1'b0;
            if (cfg_root_ppn == '0) begin
                res.kind = KIND_FAULT;
                res.address = {15'b0, va};
            end else begin
                walk_vaddr = va;
                walk_table_ppn = cfg_root_ppn;
                walk_wide_root = cfg_guest;
                walk_level = 2'(WALK_LEVELS - 1);
                walk_active = 1'b1;
                res.kind = KIND_READ;
                res.address = entry_addr();
            end
        end else begin
            if (!walk_active)
                return 1'b0;
            if (walk_level == 2'd0) begin
                // Leaf: valid bit is not looked at
                walk_active = 1'b0;
                res.kind = KIND_DONE;
                res.address = {ppn, walk_vaddr[OFFSET_W-1:0]};
            end else if (!pte[PTE_V_BIT]) begin
                walk_active = 1'b0;
                res.kind = KIND_FAULT;
                res.address = {15'b0, walk_vaddr};
            end else begin
                walk_table_ppn = ppn;
                walk_level = walk_level - 2'd1;
                res.kind = KIND_READ;
                res.address = entry_addr();
            end
        end
        pending_results.push_back(res);
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [VA_W-1:0] rand_vaddr();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[VA_W-1:0];
    endfunction

    function automatic logic [PTE_W-1:0] rand_pte();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PPN_W-1:0] rand_ppn();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[PPN_W-1:0];
    endfunction

    // Send one request and wait until it is accepted
    task automatic send_request(input logic cmd, input logic [VA_W-1:0] va,
                                input logic [PTE_W-1:0] pte);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_vaddr     <= va;
        i_read_data <= pte;
        do @(posedge i_clk); while (!o_in_ready);
        void'(predict_step(cmd, va, pte));
        counted_items++;
    endtask

    task automatic send_translate(input logic [VA_W-1:0] va);
        send_request(CMD_TRANSLATE, va, rand_pte());
    endtask

    task automatic send_response(input logic [PTE_W-1:0] pte);
        send_request(CMD_RESPONSE, rand_vaddr(), pte);
    endtask

    // Hold off new requests until every expected result has come back
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers back to back, valid held high across them
    task automatic set_config(input logic [PPN_W-1:0] ppn, input logic guest);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_ROOT_PPN;
        i_cfg_data  <= ppn;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_root_ppn = ppn;
        i_cfg_index <= CFG_GUEST_MODE;
        i_cfg_data  <= {{(PPN_W-1){1'b0}}, guest};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_guest = guest;
        i_cfg_valid <= 1'b0;
    endtask

    // Root PPN of zero faults at once; responses while idle are dropped
    task automatic test_zero_root();
        send_translate('0);
        send_translate('1);
        send_response('1);
        send_response('0);
        wait_idle();
    endtask

    // Full Sv39 walks with extreme entries and addresses
    task automatic test_sv39_walk();
        set_config(44'h1, 1'b0);
        send_translate('1);
        send_response({10'b0, {PPN_W{1'b1}}, 9'b0, 1'b1});
        send_response(64'h1);
        send_response('1);
        send_translate('0);
        send_response(64'h1);
        send_response(64'hFFFF_FFFF_FFFF_FFFF);
        send_response('0);
        wait_idle();
    endtask

    // Invalid entries above the leaf, and a request during a walk
    task automatic test_bad_entry();
        send_translate(rand_vaddr());
        send_response(64'hFFFF_FFFF_FFFF_FFFE);
        send_translate(rand_vaddr());
        send_translate('1);
        send_response({rand_pte() | 64'h1});
        send_response('0);
        wait_idle();
    endtask

    // Sv39x4 root index with the largest root PPN, address wraps at 56 bits
    task automatic test_sv39x4_walk();
        set_config({PPN_W{1'b1}}, 1'b1);
        send_translate('1);
        send_response('1);
        send_response(rand_pte() | 64'h1);
        send_response(rand_pte());
        wait_idle();
    endtask

    // Mostly complete walks with random content, some noise and broken walks
    task automatic test_random_walks(input logic [PPN_W-1:0] ppn, input logic guest);
        int unsigned start;
        logic [PTE_W-1:0] pte;
        set_config(ppn, guest);
        start = counted_items;
        while (counted_items - start < PHASE_ITEMS) begin
            burst_mode = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 85) begin
                send_translate(rand_vaddr());
                while (walk_active) begin
                    if ($urandom_range(0, 19) == 0) begin
                        send_translate(rand_vaddr());
                    end else begin
                        pte = rand_pte();
                        if (walk_level != 2'd0)
                            pte[PTE_V_BIT] = ($urandom_range(0, 9) != 0);
                        send_response(pte);
                    end
                end
            end else begin
                send_response(rand_pte());
            end
        end
        burst_mode = 1'b0;
        wait_idle();
    endtask

    // Receiver: calm stretches, random stalls and a few long ones
    always @(posedge i_clk) begin
        if ($urandom_range(0, 149) == 0)
            ready_calm = !ready_calm;
        if (ready_hold != 0) begin
            ready_hold--;
            i_out_ready <= 1'b0;
        end else if (ready_calm) begin
            i_out_ready <= 1'b1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 2)
                ready_hold = $urandom_range(10, 40);
            i_out_ready <= (ready_pick >= 25);
        end
    end

    // Compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d address %h",
                                          o_kind, o_address));
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_kind !== oldest_result.kind)
                    report_mismatch($sformatf("kind got %0d expected %0d",
                                              o_kind, oldest_result.kind));
                if (o_address !== oldest_result.address)
                    report_mismatch($sformatf("address got %h expected %h",
                                              o_address, oldest_result.address));
            end
        end
    end

    // Drop the run when no handshake happens on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no handshake for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        walk_active    = 1'b0;
        walk_level     = '0;
        walk_vaddr     = '0;
        walk_table_ppn = '0;
        walk_wide_root = 1'b0;
        cfg_root_ppn   = '0;
        cfg_guest      = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_root();
        test_sv39_walk();
        test_bad_entry();
        test_sv39x4_walk();
        test_random_walks(44'h1, 1'b0);
        test_random_walks({PPN_W{1'b1}}, 1'b1);
        test_random_walks(rand_ppn() | 44'h1, 1'b0);
        test_random_walks(rand_ppn() | 44'h1, 1'b1);
        test_random_walks('0, 1'($urandom_range(0, 1)));
        test_random_walks({PPN_W{1'b1}}, 1'b0);

        wait_idle();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/sv39ptw_pkg.sv
rtl/core/sv39ptw_addr.sv
rtl/core/sv39_page_table_walker_core.sv
sim/tb_sv39_page_table_walker_core.sv
